@@ rtl/core/modem_line_keyword_detector_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Modem line keyword detector assertion macros
// Shared concurrent assertion forms used by the checker of the detector.
// ----------------------------------------------------------------------------
`ifndef MODEM_LINE_KEYWORD_DETECTOR_UNIT_DEFINES_SVH
`define MODEM_LINE_KEYWORD_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define MLKD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define MLKD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mlkd_pkg.sv @@
// ----------------------------------------------------------------------------
// Modem line keyword detector package
// Word types, keyword codes and keyword text tables shared by the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mlkd_pkg;

   localparam int LINE_LIMIT   = 255;
   localparam int LEN_W        = $clog2(LINE_LIMIT + 1);
   localparam int NUM_KEYWORDS = 5;
   localparam int KW_CHAR_MAX  = 5;
   localparam int PROG_W       = $clog2(KW_CHAR_MAX + 1);
   localparam int NUM_FLAGS    = 4;

   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // Keyword text, one row per keyword, in priority order.
   localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KW_CHAR_MAX] = '{
      '{8'h52, 8'h44, 8'h59, 8'h00, 8'h00},   // RDY
      '{8'h4F, 8'h50, 8'h45, 8'h4E, 8'h00},   // OPEN
      '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h00},   // CONN
      '{8'h50, 8'h55, 8'h42, 8'h45, 8'h58},   // PUBEX
      '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52}    // ERROR
   };

   localparam logic [PROG_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
      PROG_W'(3), PROG_W'(4), PROG_W'(4), PROG_W'(5), PROG_W'(5)
   };

   // Configuration register indexes.
   typedef enum logic [0:0] {
      REG_KEYWORD_CHECK_ENABLE = 1'b0,
      REG_UNUSED               = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      KW_NONE  = 3'd0,
      KW_RDY   = 3'd1,
      KW_OPEN  = 3'd2,
      KW_CONN  = 3'd3,
      KW_PUBEX = 3'd4,
      KW_ERROR = 3'd5
   } keyword_type;

   typedef logic [NUM_KEYWORDS-1:0][PROG_W-1:0] progress_type;
   typedef logic [NUM_KEYWORDS-1:0]             found_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [3:0] flag_clear_mask;
   } req_word_type;

   typedef struct packed {
      logic        ready_flag;
      logic        open_flag;
      logic        conn_flag;
      logic        publish_ok_flag;
      logic        line_end;
      keyword_type matched_keyword;
      logic        overflow;
   } rsp_word_type;

   // Control from the pipeline to the line tracker.
   typedef struct packed {
      logic step;
      logic check_enable;
   } step_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/mlkd_kw_match.sv @@
// ----------------------------------------------------------------------------
// Keyword matcher
// Advances the match progress of every keyword by one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mlkd_kw_match (
   input  wire logic [7:0]           rx_byte,
   input  wire mlkd_pkg::progress_type progress,
   input  wire mlkd_pkg::found_type    found,
   output mlkd_pkg::progress_type      progress_next,
   output mlkd_pkg::found_type         found_next
);
   import mlkd_pkg::*;

   // None of the keywords has a proper border, so a mismatch falls back to
   // either zero or one matched character.
   for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_kw
      logic [PROG_W-1:0] p_start;
      logic [PROG_W-1:0] p_step;

      always_comb begin
         p_start = (progress[k] >= KW_LEN[k]) ? '0 : progress[k];
         if (KW_TEXT[k][p_start] == rx_byte) begin
            p_step = p_start + PROG_W'(1);
         end else begin
            p_step = (KW_TEXT[k][0] == rx_byte) ? PROG_W'(1) : '0;
         end

         if (found[k]) begin
            progress_next[k] = progress[k];
            found_next[k]    = 1'b1;
         end else if (p_step >= KW_LEN[k]) begin
            progress_next[k] = KW_LEN[k];
            found_next[k]    = 1'b1;
         end else begin
            progress_next[k] = p_step;
            found_next[k]    = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mlkd_line_tracker.sv @@
// ----------------------------------------------------------------------------
// Line tracker
// Holds the line state and status flags and forms one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mlkd_line_tracker #(
   parameter int LINE_LIMIT = mlkd_pkg::LINE_LIMIT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mlkd_pkg::step_ctl_type ctl,
   input  wire mlkd_pkg::req_word_type in_word,
   output mlkd_pkg::rsp_word_type      result
);
   import mlkd_pkg::*;

   logic [LEN_W-1:0]     line_length_ff, line_length_in;
   logic                 prev_cr_ff, prev_cr_in;
   logic                 zero_seen_ff, zero_seen_in;
   progress_type         progress_ff, progress_in;
   found_type            found_ff, found_in;
   logic [NUM_FLAGS-1:0] flags_ff, flags_in;

   progress_type         progress_srch;
   found_type            found_srch;
   logic [LEN_W-1:0]     len_inc;
   logic                 line_done;
   keyword_type          matched;
   logic                 overflow;

   mlkd_kw_match u_kw_match (
      .rx_byte       (in_word.rx_byte),
      .progress      (progress_ff),
      .found         (found_ff),
      .progress_next (progress_srch),
      .found_next    (found_srch)
   );

   always_comb begin
      flags_in       = flags_ff & ~in_word.flag_clear_mask;
      line_length_in = line_length_ff;
      prev_cr_in     = prev_cr_ff;
      zero_seen_in   = zero_seen_ff;
      progress_in    = progress_ff;
      found_in       = found_ff;
      line_done      = 1'b0;
      matched        = KW_NONE;
      overflow       = 1'b0;
      len_inc        = line_length_ff + LEN_W'(1);

      if (line_length_ff >= LEN_W'(LINE_LIMIT)) begin
         // Byte dropped; the line restarts empty.
         overflow       = 1'b1;
         line_length_in = '0;
         prev_cr_in     = 1'b0;
         zero_seen_in   = 1'b0;
         progress_in    = '0;
         found_in       = '0;
      end else begin
         line_length_in = len_inc;
         zero_seen_in   = zero_seen_ff | (in_word.rx_byte == CHAR_NUL);
         if (!zero_seen_in) begin
            progress_in = progress_srch;
            found_in    = found_srch;
         end
         prev_cr_in = (in_word.rx_byte == CHAR_CR);

         // A lone CR LF is not a line end.
         if (prev_cr_ff && (in_word.rx_byte == CHAR_LF) && (len_inc != LEN_W'(2))
             && ctl.check_enable) begin
            line_done = 1'b1;
            if (found_in[0]) begin
               matched = KW_RDY;
            end else if (found_in[1]) begin
               matched = KW_OPEN;
            end else if (found_in[2]) begin
               matched = KW_CONN;
            end else if (found_in[3]) begin
               matched = KW_PUBEX;
            end else if (found_in[4]) begin
               matched = KW_ERROR;
            end

            case (matched)
               KW_RDY:   flags_in[0] = 1'b1;
               KW_OPEN:  flags_in[1] = 1'b1;
               KW_CONN:  flags_in[2] = 1'b1;
               KW_PUBEX: flags_in[3] = 1'b1;
               KW_ERROR: flags_in    = '0;
               default:  flags_in    = flags_in;
            endcase

            line_length_in = '0;
            prev_cr_in     = 1'b0;
            zero_seen_in   = 1'b0;
            progress_in    = '0;
            found_in       = '0;
         end
      end

      result.ready_flag      = flags_in[0];
      result.open_flag       = flags_in[1];
      result.conn_flag       = flags_in[2];
      result.publish_ok_flag = flags_in[3];
      result.line_end        = line_done;
      result.matched_keyword = matched;
      result.overflow        = overflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
         prev_cr_ff     <= 1'b0;
         zero_seen_ff   <= 1'b0;
         progress_ff    <= '0;
         found_ff       <= '0;
         flags_ff       <= '0;
      end else if (ctl.step) begin
         line_length_ff <= line_length_in;
         prev_cr_ff     <= prev_cr_in;
         zero_seen_ff   <= zero_seen_in;
         progress_ff    <= progress_in;
         found_ff       <= found_in;
         flags_ff       <= flags_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/mlkd_csr.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the keyword check enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mlkd_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic             check_enable
);
   import mlkd_pkg::*;

   logic          check_enable_ff, check_enable_in;
   reg_index_type reg_index;
   logic          wr_en;

   always_comb begin
      reg_index       = reg_index_type'(csr_paddr[2]);
      wr_en           = csr_psel && csr_penable && csr_pwrite;
      check_enable_in = check_enable_ff;
      if (wr_en && (reg_index == REG_KEYWORD_CHECK_ENABLE)) begin
         check_enable_in = csr_pwdata[0];
      end
      case (reg_index)
         REG_KEYWORD_CHECK_ENABLE: csr_prdata = {31'b0, check_enable_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_enable_ff <= 1'b1;
      end else begin
         check_enable_ff <= check_enable_in;
      end
   end

   assign csr_pready   = 1'b1;
   assign check_enable = check_enable_ff;

endmodule

`default_nettype wire

@@ rtl/core/modem_line_keyword_detector_unit.sv @@
// ----------------------------------------------------------------------------
// Modem line keyword detector
// Counts modem receive bytes per line and reports status keywords at CR LF.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word           Handshake
//   req_     in         req_word_type  req_valid / req_stall
//   rsp_     out        rsp_word_type  rsp_valid / rsp_stall
//   csr_     in/out     32-bit APB     psel / penable, pready tied high
//
// Each accepted byte yields exactly one result word. The byte passes the
// input register, then the result register, whose word is taken at an
// edge with rsp_stall low. One byte can be accepted every cycle unless a
// stalled result word holds; the line state loop closes in the line tracker.
// Reset is synchronous and active high; it clears the line state, the flags
// and both pipeline stages, and sets the keyword check enable.
// A stalled result word holds the result register; when the input register
// also holds a byte, req_stall rises in that same cycle and the byte waits.
// ----------------------------------------------------------------------------
`default_nettype none

module modem_line_keyword_detector_unit #(
   parameter int LINE_LIMIT = mlkd_pkg::LINE_LIMIT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire mlkd_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output mlkd_pkg::rsp_word_type      rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import mlkd_pkg::*;

   // Input register stage.
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   // Result register stage.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;

   logic         out_adv;
   logic         check_enable;
   step_ctl_type ctl;
   rsp_word_type result;

   mlkd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .check_enable (check_enable)
   );

   // The result register can take a new word when it is empty or its word
   // is being taken this cycle; the input register then passes its byte on.
   always_comb begin
      out_adv          = !rsp_valid_ff || !rsp_stall;
      req_stall        = in_valid_ff && !out_adv;
      ctl.step         = in_valid_ff && out_adv;
      ctl.check_enable = check_enable;
      in_valid_in      = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in     = out_adv ? in_valid_ff : rsp_valid_ff;
   end

   mlkd_line_tracker #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_line_tracker (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .in_word (in_word_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
      if (ctl.step) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

`default_nettype wire

@@ rtl/core/mlkd_checker.sv @@
// ----------------------------------------------------------------------------
// Detector port checker
// Concurrent assertions on the ports of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modem_line_keyword_detector_unit_defines.svh"

module mlkd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire mlkd_pkg::rsp_word_type rsp_data
);
   import mlkd_pkg::*;

   // A keyword is reported only on a line end.
   `MLKD_ASSERT_IMPLY(a_kw_needs_line_end, clock, reset, rsp_valid && (rsp_data.matched_keyword != KW_NONE), rsp_data.line_end, "keyword reported without line end")

   // A dropped byte never ends a line.
   `MLKD_ASSERT_IMPLY(a_overflow_no_line_end, clock, reset, rsp_valid && rsp_data.overflow, !rsp_data.line_end && (rsp_data.matched_keyword == KW_NONE), "overflow together with line end")

   // ERROR clears every status flag.
   `MLKD_ASSERT_IMPLY(a_error_clears_flags, clock, reset, rsp_valid && rsp_data.line_end && (rsp_data.matched_keyword == KW_ERROR), !rsp_data.ready_flag && !rsp_data.open_flag && !rsp_data.conn_flag && !rsp_data.publish_ok_flag, "flags survive ERROR")

   // A stalled result word holds.
   `MLKD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result word changed")

endmodule

bind modem_line_keyword_detector_unit mlkd_checker u_mlkd_checker (.*);

`default_nettype wire
